// ===== hw/rtl/glyph_supersampled_coverage_macros.svh =====
// Assertion macros for the glyph coverage block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GLYPH_SUPERSAMPLED_COVERAGE_MACROS_SVH
`define GLYPH_SUPERSAMPLED_COVERAGE_MACROS_SVH

// same-cycle implication
`define GSC_ASSERT_IMPL(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glyph coverage check failed");

// next-cycle implication
`define GSC_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glyph coverage check failed");

`endif

// ===== hw/rtl/gsc_pkg.sv =====
// Shared constants, request codes and structs of the glyph coverage block.
// No dependencies.
package gsc_pkg;

    localparam int PTS_DEPTH       = 256;
    localparam int PTS_AW          = $clog2(PTS_DEPTH);
    localparam int PCNT_W          = PTS_AW + 1;
    localparam int VTX_DEPTH       = 2048;
    localparam int VTX_AW          = $clog2(VTX_DEPTH);
    localparam int VCNT_W          = VTX_AW + 1;
    localparam int CURVE_STEPS     = 8;
    localparam int K_W             = $clog2(CURVE_STEPS) + 1;
    localparam int CURVE_SHIFT     = $clog2(CURVE_STEPS * CURVE_STEPS);
    localparam int FRAC_BITS       = 7;
    localparam int PT_W            = 16;
    localparam int COORD_W         = 24;
    localparam int SMP_W           = COORD_W + 1;
    localparam int STEP_W          = 20;
    localparam int SAMPLES_PER_AXIS = 4;
    localparam int SA_W            = $clog2(SAMPLES_PER_AXIS);
    localparam int SAMPLES         = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;
    localparam int HITS_W          = $clog2(SAMPLES) + 1;
    localparam int HITS_SHIFT      = $clog2(SAMPLES);
    localparam int COV_W           = 8;
    localparam int COV_MAX         = 255;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(128);

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_POINT = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef struct packed {
        logic                   on;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] x;
    } raw_pt_t;

    typedef struct packed {
        logic    valid;
        logic    last;
        raw_pt_t pt;
    } pt_in_t;

    typedef struct packed {
        logic                      first;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vtx_t;

    typedef struct packed {
        logic valid;
        vtx_t v;
    } vtx_wr_t;

    typedef struct packed {
        logic rd_valid;
        logic close;
    } walk_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } res_t;

endpackage

// ===== hw/rtl/gsc_flatten.sv =====
// Outline point buffer and contour flattening sequencer.
// Depends on gsc_pkg; emits vertex writes toward gsc_vstore.
module gsc_flatten
    import gsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clr,
    input  pt_in_t  pt_in,
    output logic    busy,
    output logic    drop,
    output vtx_wr_t vw
);

    typedef enum logic [3:0] {
        F_IDLE, F_RD0, F_RDL, F_START, F_FETCHP, F_GOTP, F_GOTQ, F_CURVE, F_DONE
    } fstate_t;

    raw_pt_t mem [PTS_DEPTH];
    raw_pt_t rd_q;
    logic    rd_en;
    logic [PTS_AW-1:0] rd_addr;
    logic    wr_en;

    fstate_t st_reg, st_next;
    logic [PCNT_W-1:0] cnt_reg, cnt_next, m_reg, m_next, i_reg, i_next;
    logic b_reg, b_next, qon_reg, qon_next;
    raw_pt_t p0_reg, p0_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0] kx_reg, kx_next, ky_reg, ky_next;
    logic signed [COORD_W-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [K_W-1:0] k_reg, k_next;
    vtx_wr_t vw_reg, vw_next;

    logic [PCNT_W-1:0] nm1, p_idx, q_nxt, q_idx, i_step;
    logic signed [COORD_W-1:0] fx, fy, sx, sy;

    function automatic logic signed [COORD_W-1:0] to_fix(input logic signed [PT_W-1:0] a);
        to_fix = {{(COORD_W-PT_W-FRAC_BITS){a[PT_W-1]}}, a, {FRAC_BITS{1'b0}}};
    endfunction

    function automatic logic signed [COORD_W-1:0] mid(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        mid = s[COORD_W:1];
    endfunction

    function automatic logic signed [COORD_W-1:0] curve(input logic signed [COORD_W-1:0] c,
                                                        input logic signed [COORD_W-1:0] p,
                                                        input logic signed [COORD_W-1:0] e,
                                                        input logic [K_W-1:0] k);
        logic [K_W-1:0] u;
        logic [7:0] cu, cp, ce;
        logic signed [8:0] fu, fp, fe;
        logic signed [COORD_W+CURVE_SHIFT+2:0] s;
        u  = K_W'(CURVE_STEPS) - k;
        cu = 8'(u) * 8'(u);
        cp = (8'(u) * 8'(k)) << 1;
        ce = 8'(k) * 8'(k);
        fu = $signed({1'b0, cu});
        fp = $signed({1'b0, cp});
        fe = $signed({1'b0, ce});
        s  = c * fu + p * fp + e * fe;
        curve = s[COORD_W+CURVE_SHIFT-1:CURVE_SHIFT];
    endfunction

    assign wr_en = pt_in.valid && !cnt_reg[PTS_AW];
    assign drop  = pt_in.valid && cnt_reg[PTS_AW];
    assign busy  = (st_reg != F_IDLE) || vw_reg.valid;
    assign vw    = vw_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[PTS_AW-1:0]] <= pt_in.pt;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    assign nm1    = cnt_reg - PCNT_W'(1);
    assign p_idx  = PCNT_W'(b_reg) + i_reg;
    assign q_nxt  = p_idx + PCNT_W'(1);
    assign q_idx  = (q_nxt == cnt_reg) ? '0 : q_nxt;
    assign i_step = i_reg + (qon_reg ? PCNT_W'(2) : PCNT_W'(1));
    assign fx     = to_fix(rd_q.x);
    assign fy     = to_fix(rd_q.y);
    assign sx     = curve(cx_reg, kx_reg, ex_reg, k_reg);
    assign sy     = curve(cy_reg, ky_reg, ey_reg, k_reg);

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        m_next   = m_reg;
        i_next   = i_reg;
        b_next   = b_reg;
        qon_next = qon_reg;
        p0_next  = p0_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        kx_next  = kx_reg;
        ky_next  = ky_reg;
        ex_next  = ex_reg;
        ey_next  = ey_reg;
        k_next   = k_reg;
        vw_next  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        case (st_reg)
            F_IDLE:
            begin
                if (clr)
                begin
                    cnt_next = '0;
                end
                if (pt_in.valid)
                begin
                    if (wr_en)
                    begin
                        cnt_next = cnt_reg + PCNT_W'(1);
                    end
                    if (pt_in.last)
                    begin
                        st_next = F_RD0;
                    end
                end
            end
            F_RD0:
            begin
                rd_en   = 1'b1;
                st_next = F_RDL;
            end
            F_RDL:
            begin
                p0_next = rd_q;
                rd_en   = 1'b1;
                rd_addr = nm1[PTS_AW-1:0];
                st_next = F_START;
            end
            F_START:
            begin
                if (p0_reg.on)
                begin
                    cx_next = to_fix(p0_reg.x);
                    cy_next = to_fix(p0_reg.y);
                    b_next  = 1'b1;
                    m_next  = nm1;
                end
                else if (rd_q.on)
                begin
                    cx_next = fx;
                    cy_next = fy;
                    b_next  = 1'b0;
                    m_next  = nm1;
                end
                else
                begin
                    cx_next = mid(fx, to_fix(p0_reg.x));
                    cy_next = mid(fy, to_fix(p0_reg.y));
                    b_next  = 1'b0;
                    m_next  = cnt_reg;
                end
                vw_next = '{valid: 1'b1, v: '{first: 1'b1, y: cy_next, x: cx_next}};
                i_next  = '0;
                st_next = (m_next != '0) ? F_FETCHP : F_DONE;
            end
            F_FETCHP:
            begin
                rd_en   = 1'b1;
                rd_addr = p_idx[PTS_AW-1:0];
                st_next = F_GOTP;
            end
            F_GOTP:
            begin
                if (rd_q.on)
                begin
                    vw_next = '{valid: 1'b1, v: '{first: 1'b0, y: fy, x: fx}};
                    cx_next = fx;
                    cy_next = fy;
                    i_next  = i_reg + PCNT_W'(1);
                    st_next = (i_next < m_reg) ? F_FETCHP : F_DONE;
                end
                else
                begin
                    kx_next = fx;
                    ky_next = fy;
                    rd_en   = 1'b1;
                    rd_addr = q_idx[PTS_AW-1:0];
                    st_next = F_GOTQ;
                end
            end
            F_GOTQ:
            begin
                qon_next = rd_q.on;
                ex_next  = rd_q.on ? fx : mid(kx_reg, fx);
                ey_next  = rd_q.on ? fy : mid(ky_reg, fy);
                k_next   = K_W'(1);
                st_next  = F_CURVE;
            end
            F_CURVE:
            begin
                vw_next = '{valid: 1'b1, v: '{first: 1'b0, y: sy, x: sx}};
                if (k_reg == K_W'(CURVE_STEPS))
                begin
                    cx_next = ex_reg;
                    cy_next = ey_reg;
                    i_next  = i_step;
                    st_next = (i_step < m_reg) ? F_FETCHP : F_DONE;
                end
                else
                begin
                    k_next = k_reg + K_W'(1);
                end
            end
            F_DONE:
            begin
                cnt_next = '0;
                st_next  = F_IDLE;
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= F_IDLE;
            cnt_reg <= '0;
            vw_reg  <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            vw_reg  <= vw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        i_reg   <= i_next;
        b_reg   <= b_next;
        qon_reg <= qon_next;
        p0_reg  <= p0_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        kx_reg  <= kx_next;
        ky_reg  <= ky_next;
        ex_reg  <= ex_next;
        ey_reg  <= ey_next;
        k_reg   <= k_next;
    end

endmodule

// ===== hw/rtl/gsc_vstore.sv =====
// Vertex store: one write port, one registered read port, fill count.
// Depends on gsc_pkg.
module gsc_vstore
    import gsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr,
    input  vtx_wr_t           vw,
    input  logic              rd_en,
    input  logic [VTX_AW-1:0] rd_addr,
    output vtx_t              rd_q,
    output logic [VCNT_W-1:0] count,
    output logic              drop
);

    vtx_t mem [VTX_DEPTH];
    logic [VCNT_W-1:0] count_reg;
    logic wr_en;

    assign wr_en = vw.valid && !count_reg[VTX_AW];
    assign drop  = vw.valid && count_reg[VTX_AW];
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[VTX_AW-1:0]] <= vw.v;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clr)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_reg + VCNT_W'(1);
        end
    end

endmodule

// ===== hw/rtl/gsc_cross.sv =====
// Even-odd crossing pipeline: edge forming, cross-multiply, parity toggle.
// Depends on gsc_pkg; fed one vertex per cycle from gsc_vstore.
module gsc_cross
    import gsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  walk_t                   walk,
    input  vtx_t                    vtx,
    input  logic signed [SMP_W-1:0] smp_x,
    input  logic signed [SMP_W-1:0] smp_y,
    output res_t                    res
);

    localparam int DIF_W  = SMP_W + 1;
    localparam int PROD_W = 2 * DIF_W;

    vtx_t prev_reg, start_reg;
    logic prev_v_reg;

    logic edge_v, crosses;
    vtx_t ea, eb;
    logic signed [SMP_W-1:0] ay, by;

    logic e2_v_reg, e2_last_reg, e2_dpos_reg;
    logic signed [DIF_W-1:0] dx2_reg, d2_reg, ex2_reg, dy2_reg;
    logic e3_v_reg, e3_last_reg, e3_dpos_reg;
    logic signed [PROD_W-1:0] lhs3_reg, rhs3_reg;
    logic inside_reg, flip, now_in;
    res_t res_reg;

    always_comb
    begin
        ea     = prev_reg;
        eb     = start_reg;
        edge_v = 1'b0;
        if (walk.rd_valid)
        begin
            edge_v = prev_v_reg;
            eb     = vtx.first ? start_reg : vtx;
        end
        else if (walk.close)
        begin
            edge_v = prev_v_reg;
        end
    end

    assign ay      = SMP_W'(ea.y);
    assign by      = SMP_W'(eb.y);
    assign crosses = (ay > smp_y) != (by > smp_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_v_reg  <= 1'b0;
            e2_v_reg    <= 1'b0;
            e2_last_reg <= 1'b0;
            e3_v_reg    <= 1'b0;
            e3_last_reg <= 1'b0;
            inside_reg  <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            if (walk.rd_valid)
            begin
                prev_v_reg <= 1'b1;
            end
            else if (walk.close)
            begin
                prev_v_reg <= 1'b0;
            end
            e2_v_reg    <= edge_v && crosses;
            e2_last_reg <= walk.close;
            e3_v_reg    <= e2_v_reg;
            e3_last_reg <= e2_last_reg;
            res_reg     <= '{valid: e3_last_reg, hit: now_in};
            inside_reg  <= e3_last_reg ? 1'b0 : now_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk.rd_valid)
        begin
            prev_reg <= vtx;
            if (vtx.first)
            begin
                start_reg <= vtx;
            end
        end
        e2_dpos_reg <= by > ay;
        d2_reg      <= DIF_W'(by) - DIF_W'(ay);
        dx2_reg     <= DIF_W'(smp_x) - DIF_W'(ea.x);
        ex2_reg     <= DIF_W'(eb.x) - DIF_W'(ea.x);
        dy2_reg     <= DIF_W'(smp_y) - DIF_W'(ay);
        e3_dpos_reg <= e2_dpos_reg;
        lhs3_reg    <= dx2_reg * d2_reg;
        rhs3_reg    <= ex2_reg * dy2_reg;
    end

    assign flip   = e3_v_reg && (e3_dpos_reg ? (lhs3_reg < rhs3_reg) : (lhs3_reg > rhs3_reg));
    assign now_in = inside_reg ^ flip;
    assign res    = res_reg;

endmodule

// ===== hw/rtl/glyph_supersampled_coverage.sv =====
// Top level of the glyph coverage block: request decode, query sequencer, result register.
// Depends on gsc_pkg, gsc_flatten, gsc_vstore, gsc_cross and the macros header.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    req_type point_x point_y on_curve
//                                              contour_last origin_x origin_y
//  result    out        out_valid / out_stall  coverage overflow
//  config    in         cfg_valid / cfg_ready  cfg_data (sample_step)
//
// A contour end runs the flattening sequencer over the buffered points, one point-buffer
// read each step. A query walks the stored vertices once for each of the 16 subsamples:
// the vertex store gives one vertex a cycle and each subsample waits for the crossing
// pipeline to drain.
// rst_n clears control state asynchronously; buffer contents stay unknown until written.
// A result waits in the output register under out_stall while new items are taken.
`include "glyph_supersampled_coverage_macros.svh"

module glyph_supersampled_coverage
    import gsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic signed [PT_W-1:0]    point_x,
    input  logic signed [PT_W-1:0]    point_y,
    input  logic                      on_curve,
    input  logic                      contour_last,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COV_W-1:0]          coverage,
    output logic                      overflow,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [STEP_W-1:0]         cfg_data
);

    typedef enum logic [1:0] {
        T_IDLE, T_WALK, T_WAIT, T_RESULT
    } tstate_t;

    tstate_t state_reg;
    logic accept, is_clr, is_pt, is_q;
    pt_in_t pt_in;
    logic flat_busy, pt_drop, v_drop;
    vtx_wr_t vw;
    logic rd_en, close_now, load;
    vtx_t rd_q;
    logic [VCNT_W-1:0] vcount, r_reg;
    walk_t walk_reg;
    res_t res;

    logic [STEP_W-1:0] step_reg;
    logic ovf_reg;
    logic signed [COORD_W-1:0] org_x_reg;
    logic signed [SMP_W-1:0] smp_x_reg, smp_y_reg;
    logic [SA_W-1:0] sx_reg, sy_reg;
    logic [HITS_W-1:0] hits_reg, hits_sum;
    logic [HITS_W+COV_W-1:0] prod;
    logic out_valid_reg, overflow_reg;
    logic [COV_W-1:0] coverage_reg;

    assign in_stall  = (state_reg != T_IDLE) || flat_busy;
    assign accept    = in_valid && !in_stall;
    assign is_clr    = accept && (req_type == REQ_CLEAR);
    assign is_pt     = accept && (req_type == REQ_POINT);
    assign is_q      = accept && (req_type == REQ_QUERY);
    assign cfg_ready = 1'b1;

    assign pt_in = '{valid: is_pt, last: contour_last,
                     pt: '{on: on_curve, y: point_y, x: point_x}};

    gsc_flatten u_flatten (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (is_clr),
        .pt_in (pt_in),
        .busy  (flat_busy),
        .drop  (pt_drop),
        .vw    (vw)
    );

    assign rd_en     = (state_reg == T_WALK) && (r_reg < vcount);
    assign close_now = (state_reg == T_WALK) && !(r_reg < vcount);

    gsc_vstore u_vstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (is_clr),
        .vw      (vw),
        .rd_en   (rd_en),
        .rd_addr (r_reg[VTX_AW-1:0]),
        .rd_q    (rd_q),
        .count   (vcount),
        .drop    (v_drop)
    );

    gsc_cross u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .walk  (walk_reg),
        .vtx   (rd_q),
        .smp_x (smp_x_reg),
        .smp_y (smp_y_reg),
        .res   (res)
    );

    assign hits_sum = hits_reg + HITS_W'(res.hit);
    assign prod     = (HITS_W+COV_W)'(hits_reg) * (HITS_W+COV_W)'(COV_MAX);
    assign load     = (state_reg == T_RESULT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            step_reg      <= STEP_RESET;
            ovf_reg       <= 1'b0;
            walk_reg      <= '0;
            r_reg         <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            hits_reg      <= '0;
            org_x_reg     <= '0;
            smp_x_reg     <= '0;
            smp_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            coverage_reg  <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                step_reg <= cfg_data;
            end
            if (is_clr)
            begin
                ovf_reg <= 1'b0;
            end
            else if (pt_drop || v_drop)
            begin
                ovf_reg <= 1'b1;
            end
            walk_reg <= '{rd_valid: rd_en, close: close_now};
            if (load)
            begin
                out_valid_reg <= 1'b1;
                coverage_reg  <= prod[HITS_SHIFT+COV_W-1:HITS_SHIFT];
                overflow_reg  <= ovf_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (is_q)
                    begin
                        org_x_reg <= origin_x;
                        smp_x_reg <= SMP_W'(origin_x);
                        smp_y_reg <= SMP_W'(origin_y);
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        r_reg     <= '0;
                        hits_reg  <= '0;
                        state_reg <= T_WALK;
                    end
                end
                T_WALK:
                begin
                    if (rd_en)
                    begin
                        r_reg <= r_reg + VCNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= T_WAIT;
                    end
                end
                T_WAIT:
                begin
                    if (res.valid)
                    begin
                        hits_reg <= hits_sum;
                        r_reg    <= '0;
                        if ((sx_reg == SA_W'(SAMPLES_PER_AXIS - 1)) &&
                            (sy_reg == SA_W'(SAMPLES_PER_AXIS - 1)))
                        begin
                            state_reg <= T_RESULT;
                        end
                        else
                        begin
                            if (sx_reg == SA_W'(SAMPLES_PER_AXIS - 1))
                            begin
                                sx_reg    <= '0;
                                sy_reg    <= sy_reg + SA_W'(1);
                                smp_x_reg <= SMP_W'(org_x_reg);
                                smp_y_reg <= smp_y_reg + SMP_W'(step_reg);
                            end
                            else
                            begin
                                sx_reg    <= sx_reg + SA_W'(1);
                                smp_x_reg <= smp_x_reg + SMP_W'(step_reg);
                            end
                            state_reg <= T_WALK;
                        end
                    end
                end
                T_RESULT:
                begin
                    if (load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign coverage  = coverage_reg;
    assign overflow  = overflow_reg;

    `GSC_ASSERT_IMPL(a_flat_only_idle, flat_busy, state_reg == T_IDLE)
    `GSC_ASSERT_IMPL(a_res_in_wait, res.valid, state_reg == T_WAIT)
    `GSC_ASSERT_NEXT(a_query_walks, is_q, (state_reg == T_WALK) && (hits_reg == '0))
    `GSC_ASSERT_IMPL(a_vcount_bound, 1'b1, vcount <= VCNT_W'(VTX_DEPTH))

endmodule
